### rtl/core/crs_pkg.sv
// crs_pkg: shared types and codes for the clock reference selector
// sample and result payload structs, decision command struct and mode codes
// no dependencies
`timescale 1ns / 1ps

package crs_pkg;

  localparam int WINDOW_W = 16;
  localparam int INDEX_W  = 4;

  localparam logic [1:0] MODE_INT = 2'd0;
  localparam logic [1:0] MODE_EXT = 2'd1;
  localparam logic [1:0] MODE_OFF = 2'd2;

  typedef struct packed {
    logic gps_present;
    logic ext_ref_level;
    logic want_internal;
  } sample_t;

  typedef struct packed {
    logic               led_top;
    logic               led_middle;
    logic               led_bottom;
    logic               pps_internal;
    logic               program_valid;
    logic               table_select;
    logic [INDEX_W-1:0] reg_index;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       pps;
  } cmd_t;

endpackage

### rtl/core/clock_reference_selector.sv
// clock_reference_selector: top level of the reference selector
// path: a deciding sample's command is queued in crs_cmd_fifo, then its results pass the result register
// throughput: one sample per cycle; one result per cycle while pop is high, NUM_REGS per source
// decision; input stalls only when FIFO_DEPTH decisions are queued behind the result register
// reset: synchronous active-high rst clears all control state, window register to 65535
// depends on crs_pkg, crs_front, crs_cmd_fifo, crs_back
`timescale 1ns / 1ps

module clock_reference_selector #(
  parameter int NUM_REGS   = 9,
  parameter int FIFO_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crs_pkg::WINDOW_W-1:0]  cfg_data,
  input  logic                          push,
  output logic                          full,
  input  crs_pkg::sample_t              sample,
  output logic                          empty,
  input  logic                          pop,
  output crs_pkg::result_t              result
);
  import crs_pkg::*;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_out;
  logic take;

  assign full = cmd_full;
  assign take = push && !cmd_full;

  crs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .take      (take),
    .sample    (sample),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  crs_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .empty   (cmd_empty),
    .rd_data (cmd_out)
  );

  crs_back #(
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### rtl/core/crs_front.sv
// crs_front: window tracking, presence detection and source decision
// emits one decision command per decision; depends on crs_pkg
`timescale 1ns / 1ps

module crs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crs_pkg::WINDOW_W-1:0]    cfg_data,
  input  logic                            take,
  input  crs_pkg::sample_t                sample,
  output logic                            cmd_push,
  output crs_pkg::cmd_t                   cmd
);
  import crs_pkg::*;

  logic [WINDOW_W-1:0] activity_window;
  logic                in_window;
  logic [WINDOW_W-1:0] window_count;
  logic [WINDOW_W-1:0] count_next;
  logic                prev_level;
  logic                internal_latched;
  logic                old_switch;
  logic                old_ext_present;
  logic                first_decision;
  logic                pps_select;

  logic       changed;
  logic       close;
  logic       decide;
  logic [1:0] mode;

  assign cfg_ready  = 1'b1;
  assign count_next = window_count + 1'b1;
  assign changed    = sample.ext_ref_level != prev_level;
  assign close      = in_window && (changed || (count_next >= activity_window));
  assign decide     = close && (first_decision || (sample.want_internal != old_switch)
                      || (changed != old_ext_present));

  always_comb begin
    if (sample.want_internal) begin
      mode = internal_latched ? MODE_INT : (changed ? MODE_EXT : MODE_OFF);
    end else begin
      mode = changed ? MODE_EXT : (internal_latched ? MODE_INT : MODE_OFF);
    end
  end

  assign cmd_push = take && decide;
  assign cmd.mode = mode;
  assign cmd.pps  = pps_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      activity_window  <= '1;
      in_window        <= 1'b0;
      window_count     <= '0;
      prev_level       <= 1'b0;
      internal_latched <= 1'b0;
      old_switch       <= 1'b0;
      old_ext_present  <= 1'b0;
      first_decision   <= 1'b1;
      pps_select       <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        activity_window <= cfg_data;
      end
      if (take) begin
        if (!in_window) begin
          in_window        <= 1'b1;
          window_count     <= '0;
          internal_latched <= sample.gps_present;
          prev_level       <= sample.ext_ref_level;
        end else begin
          window_count <= count_next;
          if (close) begin
            in_window <= 1'b0;
          end
          if (decide) begin
            first_decision  <= 1'b0;
            old_switch      <= sample.want_internal;
            old_ext_present <= changed;
            if (mode == MODE_INT) begin
              pps_select <= 1'b1;
            end else if (mode == MODE_EXT) begin
              pps_select <= 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

### rtl/core/crs_cmd_fifo.sv
// crs_cmd_fifo: short first-word-fall-through queue of decision commands
// decouples the decision front from the result back; depends on crs_pkg
`timescale 1ns / 1ps

module crs_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  crs_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output crs_pkg::cmd_t rd_data
);
  import crs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/crs_back.sv
// crs_back: expands decision commands into register-write results
// one result per cycle into an output register while it is empty or popped; depends on crs_pkg
`timescale 1ns / 1ps

module crs_back #(
  parameter int NUM_REGS = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  crs_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             empty,
  input  logic             pop,
  output crs_pkg::result_t result
);
  import crs_pkg::*;

  logic [INDEX_W-1:0] idx;
  logic               out_valid;
  logic               load;
  logic               at_last;
  result_t            item;

  assign at_last = (cmd.mode == MODE_OFF) || (idx == INDEX_W'(NUM_REGS - 1));
  assign load    = !cmd_empty && (!out_valid || pop);
  assign cmd_pop = load && at_last;
  assign empty   = !out_valid;

  always_comb begin
    item = '0;
    case (cmd.mode)
      MODE_INT: begin
        item.led_top       = 1'b1;
        item.led_bottom    = 1'b1;
        item.pps_internal  = 1'b1;
        item.program_valid = 1'b1;
        item.reg_index     = idx;
        item.last          = at_last;
      end
      MODE_EXT: begin
        item.led_middle    = 1'b1;
        item.led_bottom    = 1'b1;
        item.program_valid = 1'b1;
        item.table_select  = 1'b1;
        item.reg_index     = idx;
        item.last          = at_last;
      end
      default: begin
        item.pps_internal = cmd.pps;
        item.last         = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
